// ----- rtl/mfek_pkg.sv -----
// Shared types, constants and command/status bundles for the max-flow block.
`timescale 1ns / 1ps
package mfek_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int CAP_BITS_DEF     = 16;

  localparam int VTX_W  = 6;   // vertex field width
  localparam int CNT_W  = 7;   // vertex count width
  localparam int ECAP_W = 16;  // edge capacity field width
  localparam int OUT_W  = 22;  // max flow width
  localparam int CFG_W  = 7;   // widest configuration register

  typedef enum logic [1:0] {
    CFG_VERTEX_COUNT = 2'd0,
    CFG_SOURCE       = 2'd1,
    CFG_SINK         = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_BFS_INIT,
    S_POP,
    S_RD,
    S_CHK,
    S_BN_INIT,
    S_BN_RD,
    S_BN_CHK,
    S_UP_INIT,
    S_UP_RD,
    S_UP_FWD,
    S_UP_REV,
    S_OUT
  } state_t;

  typedef struct packed {
    logic clr_start;
    logic clr_step;
    logic load;
    logic flow_clr;
    logic bfs_init;
    logic pop;
    logic scan_rd;
    logic scan_chk;
    logic walk_init;
    logic bn_set;
    logic walk_rd;
    logic bn_chk;
    logic up_fwd;
    logic up_rev;
    logic flow_add;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic term_bad;
    logic queue_empty;
    logic scan_end;
    logic scan_hit;
    logic hit_sink;
    logic walk_done;
  } sts_t;

endpackage

// ----- rtl/mfek_ctrl.sv -----
// Controller state machine: sequences loading, searches, augmentation and clearing.
`timescale 1ns / 1ps
module mfek_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           in_last_edge,
  input  mfek_pkg::sts_t sts,
  output mfek_pkg::cmd_t cmd,
  output logic           busy,
  output logic           out_valid
);
  import mfek_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:    if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (start && in_last_edge) state_nxt = S_CHECK;
      S_CHECK:    state_nxt = sts.term_bad ? S_OUT : S_BFS_INIT;
      S_BFS_INIT: state_nxt = S_POP;
      S_POP:      state_nxt = sts.queue_empty ? S_OUT : S_RD;
      S_RD:       state_nxt = sts.scan_end ? S_POP : S_CHK;
      S_CHK:      state_nxt = (sts.scan_hit && sts.hit_sink) ? S_BN_INIT : S_RD;
      S_BN_INIT:  state_nxt = S_BN_RD;
      S_BN_RD:    state_nxt = sts.walk_done ? S_UP_INIT : S_BN_CHK;
      S_BN_CHK:   state_nxt = S_BN_RD;
      S_UP_INIT:  state_nxt = S_UP_RD;
      S_UP_RD:    state_nxt = sts.walk_done ? S_BFS_INIT : S_UP_FWD;
      S_UP_FWD:   state_nxt = S_UP_REV;
      S_UP_REV:   state_nxt = S_UP_RD;
      S_OUT:      state_nxt = S_CLEAR;
      default:    state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      S_CLEAR:    cmd.clr_step = 1'b1;
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_CHECK:    cmd.flow_clr = 1'b1;
      S_BFS_INIT: cmd.bfs_init = 1'b1;
      S_POP:      cmd.pop = !sts.queue_empty;
      S_RD:       cmd.scan_rd = !sts.scan_end;
      S_CHK:      cmd.scan_chk = 1'b1;
      S_BN_INIT: begin
        cmd.walk_init = 1'b1;
        cmd.bn_set    = 1'b1;
      end
      S_BN_RD:    cmd.walk_rd = !sts.walk_done;
      S_BN_CHK:   cmd.bn_chk = 1'b1;
      S_UP_INIT:  cmd.walk_init = 1'b1;
      S_UP_RD: begin
        cmd.walk_rd  = !sts.walk_done;
        cmd.flow_add = sts.walk_done;
      end
      S_UP_FWD:   cmd.up_fwd = 1'b1;
      S_UP_REV:   cmd.up_rev = 1'b1;
      S_OUT: begin
        out_valid     = 1'b1;
        cmd.clr_start = 1'b1;
      end
      default:    busy = 1'b1;
    endcase
  end

endmodule

// ----- rtl/mfek_dp.sv -----
// Datapath: configuration, residual matrix memory, search queue and flow arithmetic.
`timescale 1ns / 1ps
module mfek_dp #(
  parameter int MAX_VERTICES = mfek_pkg::MAX_VERTICES_DEF,
  parameter int CAP_BITS     = mfek_pkg::CAP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  mfek_pkg::cfg_idx_t            cfg_index,
  input  logic [mfek_pkg::CFG_W-1:0]    cfg_data,
  input  logic [mfek_pkg::VTX_W-1:0]    in_from_vertex,
  input  logic [mfek_pkg::VTX_W-1:0]    in_to_vertex,
  input  logic [mfek_pkg::ECAP_W-1:0]   in_edge_capacity,
  input  mfek_pkg::cmd_t                cmd,
  output mfek_pkg::sts_t                sts,
  output logic [mfek_pkg::OUT_W-1:0]    out_max_flow
);
  import mfek_pkg::*;

  localparam int VW    = $clog2(MAX_VERTICES);
  localparam int AW    = 2 * VW;
  localparam int DEPTH = 1 << AW;
  localparam int RW    = CAP_BITS + 1;
  localparam logic [CNT_W-1:0] MV_CLIP =
    (MAX_VERTICES > 127) ? 7'd127 : CNT_W'(MAX_VERTICES);

  logic [CNT_W-1:0] vcount_r;
  logic [VTX_W-1:0] src_r;
  logic [VTX_W-1:0] snk_r;

  logic [RW-1:0]    res_mem [DEPTH];
  logic [RW-1:0]    rdata_r;

  logic [MAX_VERTICES-1:0] visited_r;
  logic [VW-1:0]    parent_r [MAX_VERTICES];
  logic [VW-1:0]    queue_r  [MAX_VERTICES];
  logic [CNT_W-1:0] head_r;
  logic [CNT_W-1:0] tail_r;
  logic [CNT_W-1:0] v_r;
  logic [VW-1:0]    u_r;
  logic [VW-1:0]    w_r;
  logic [VW-1:0]    pw_r;
  logic [RW-1:0]    bneck_r;
  logic [OUT_W-1:0] flow_r;
  logic [AW-1:0]    clr_r;

  logic [CNT_W-1:0] n_eff;
  logic             edge_ok;
  logic [VW-1:0]    v_idx;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [RW-1:0]    wr_data;

  assign n_eff   = (vcount_r > MV_CLIP) ? MV_CLIP : vcount_r;
  assign edge_ok = ({1'b0, in_from_vertex} < n_eff) && ({1'b0, in_to_vertex} < n_eff);
  assign v_idx   = VW'(v_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= CNT_W'(2);
      src_r    <= '0;
      snk_r    <= VTX_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VERTEX_COUNT: vcount_r <= cfg_data;
        CFG_SOURCE:       src_r    <= cfg_data[VTX_W-1:0];
        CFG_SINK:         snk_r    <= cfg_data[VTX_W-1:0];
        default:          vcount_r <= vcount_r;
      endcase
    end
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    priority if (cmd.scan_rd) begin
      rd_addr = {u_r, v_idx};
    end else if (cmd.walk_rd) begin
      rd_addr = {pw_r, w_r};
    end else if (cmd.up_fwd) begin
      rd_addr = {w_r, pw_r};
    end else begin
      rd_en = 1'b0;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    priority if (cmd.clr_step) begin
      wr_addr = clr_r;
    end else if (cmd.load && edge_ok) begin
      wr_addr = {VW'(in_from_vertex), VW'(in_to_vertex)};
      wr_data = RW'(CAP_BITS'(in_edge_capacity));
    end else if (cmd.up_fwd) begin
      wr_addr = {pw_r, w_r};
      wr_data = rdata_r - bneck_r;
    end else if (cmd.up_rev) begin
      wr_addr = {w_r, pw_r};
      wr_data = rdata_r + bneck_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      res_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= res_mem[rd_addr];
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_start) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  // Search, walk and flow registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tail_r    <= '0;
      visited_r <= '0;
      flow_r    <= '0;
    end else begin
      if (cmd.flow_clr) begin
        flow_r <= '0;
      end else if (cmd.flow_add) begin
        flow_r <= flow_r + OUT_W'(bneck_r);
      end
      if (cmd.bfs_init) begin
        visited_r  <= MAX_VERTICES'(1) << VW'(src_r);
        queue_r[0] <= VW'(src_r);
        head_r     <= '0;
        tail_r     <= CNT_W'(1);
      end
      if (cmd.pop) begin
        u_r    <= queue_r[VW'(head_r)];
        head_r <= head_r + CNT_W'(1);
        v_r    <= '0;
      end
      if (cmd.scan_chk) begin
        v_r <= v_r + CNT_W'(1);
        if (sts.scan_hit) begin
          parent_r[v_idx] <= u_r;
          if (!sts.hit_sink) begin
            queue_r[VW'(tail_r)] <= v_idx;
            tail_r               <= tail_r + CNT_W'(1);
            visited_r[v_idx]     <= 1'b1;
          end
        end
      end
      // Walk position and its parent, fetched one step ahead
      if (cmd.walk_init) begin
        w_r  <= VW'(snk_r);
        pw_r <= parent_r[VW'(snk_r)];
      end
      if (cmd.bn_set) begin
        bneck_r <= '1;
      end
      if (cmd.bn_chk) begin
        if (rdata_r < bneck_r) begin
          bneck_r <= rdata_r;
        end
        w_r  <= pw_r;
        pw_r <= parent_r[pw_r];
      end
      if (cmd.up_rev) begin
        w_r  <= pw_r;
        pw_r <= parent_r[pw_r];
      end
    end
  end

  always_comb begin
    sts.clr_last    = &clr_r;
    sts.term_bad    = ({1'b0, src_r} >= n_eff) || ({1'b0, snk_r} >= n_eff) ||
                      (src_r == snk_r);
    sts.queue_empty = (head_r == tail_r);
    sts.scan_end    = (v_r == n_eff);
    sts.scan_hit    = !visited_r[v_idx] && (rdata_r != '0);
    sts.hit_sink    = (v_r == {1'b0, snk_r});
    sts.walk_done   = (w_r == VW'(src_r));
  end

  assign out_max_flow = flow_r;

endmodule

// ----- rtl/max_flow_edmonds_karp.sv -----
// Top level of the Edmonds-Karp maximum flow block.
`timescale 1ns / 1ps
// Usage:
//   Configuration: write vertex_count (index 0), source_vertex (1) and
//   sink_vertex (2) through cfg_we/cfg_index/cfg_data while the block is idle.
//   Input: one directed edge request per cycle is taken when start is high
//   and busy is low. Each request stores its capacity in the residual matrix,
//   overwriting an earlier edge with the same ends; edges with an end at or
//   beyond the vertex count are dropped.
//   A request with in_last_edge set starts the flow computation: repeated
//   breadth-first searches in ascending vertex order, each followed by a
//   bottleneck walk and a residual update walk over the path.
//   Computation: each search examines matrix entries one at a time, and
//   each augmentation walks the path edges for the bottleneck and again
//   for the update, all bound by the single residual memory read port.
//   Result: out_valid pulses for one cycle with out_max_flow; the receiver
//   cannot stall and must take it then.
//   Clearing: after reset and after each result the matrix is zeroed one
//   entry per cycle, all (2**clog2(MAX_VERTICES))**2 entries (4096 by default),
//   with busy high; configuration writes are still taken.
module max_flow_edmonds_karp #(
  parameter int MAX_VERTICES = mfek_pkg::MAX_VERTICES_DEF,
  parameter int CAP_BITS     = mfek_pkg::CAP_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  mfek_pkg::cfg_idx_t            cfg_index,
  input  logic [mfek_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          start,
  output logic                          busy,
  input  logic [mfek_pkg::VTX_W-1:0]    in_from_vertex,
  input  logic [mfek_pkg::VTX_W-1:0]    in_to_vertex,
  input  logic [mfek_pkg::ECAP_W-1:0]   in_edge_capacity,
  input  logic                          in_last_edge,
  output logic                          out_valid,
  output logic [mfek_pkg::OUT_W-1:0]    out_max_flow
);
  import mfek_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer: owns busy and the result strobe
  mfek_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_last_edge (in_last_edge),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid)
  );

  // Storage and arithmetic; the flow total register drives the result port
  mfek_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .CAP_BITS     (CAP_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_from_vertex   (in_from_vertex),
    .in_to_vertex     (in_to_vertex),
    .in_edge_capacity (in_edge_capacity),
    .cmd              (cmd),
    .sts              (sts),
    .out_max_flow     (out_max_flow)
  );

endmodule

// ----- rtl/mfek_chk.sv -----
// Port-level checker for the max-flow block, bound to the top level.
`timescale 1ns / 1ps
module mfek_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_last_edge,
  input logic out_valid
);

  // A result strobe lasts one cycle
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  // Results appear only while the block is busy
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while idle");

  // The matrix clear follows every result
  a_clear_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> busy) else $error("no clear after result");

  // A request that is not last never yields a result next cycle
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_edge) |=> !out_valid) else $error("unexpected result");

endmodule

bind max_flow_edmonds_karp mfek_chk u_mfek_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_last_edge (in_last_edge),
  .out_valid    (out_valid)
);
